@@ rtl/result_container_parser_defines.svh @@
// assertion macros used by the rtl queue
`ifndef RESULT_CONTAINER_PARSER_DEFINES_SVH
`define RESULT_CONTAINER_PARSER_DEFINES_SVH

// same-cycle implication
`define CRP_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("crp assertion failed");

// next-cycle implication
`define CRP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("crp assertion failed");

`endif

@@ rtl/crp_pkg.sv @@
`default_nettype none

package crp_pkg;

   localparam int SIZE_FIELD_BYTES_DEF = 8;
   localparam int QUEUE_DEPTH_DEF      = 2;
   localparam int SIZE_W               = 64;

   localparam logic [7:0] VERSION_RST = 8'd0;
   localparam logic [7:0] LIMIT_RST   = 8'd10;

   localparam logic [0:0] CSR_EXPECTED_VERSION = 1'd0;
   localparam logic [0:0] CSR_ENTRY_LIMIT      = 1'd1;

   localparam logic [2:0] EV_HEADER  = 3'd0;
   localparam logic [2:0] EV_START   = 3'd1;
   localparam logic [2:0] EV_PAYLOAD = 3'd2;
   localparam logic [2:0] EV_RAW     = 3'd3;
   localparam logic [2:0] EV_ERROR   = 3'd4;

   localparam logic [1:0] ERR_BAD_VERSION   = 2'd0;
   localparam logic [1:0] ERR_TOO_MANY      = 2'd1;
   localparam logic [1:0] ERR_UNKNOWN_MARK  = 2'd2;
   localparam logic [1:0] ERR_TRUNCATED     = 2'd3;

   typedef struct packed {
      logic [2:0]        event_res;
      logic [7:0]        hdr_version;
      logic [7:0]        entry_count;
      logic [7:0]        entry_index;
      logic [7:0]        item_type;
      logic [SIZE_W-1:0] item_size;
      logic [7:0]        data_byte;
      logic              payload_last;
      logic              all_done;
      logic [1:0]        error_code;
   } res_type;

   typedef struct packed {
      logic    vld;
      res_type res;
   } push_type;

endpackage

`default_nettype wire

@@ rtl/crp_req_if.sv @@
`default_nettype none

interface crp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       stream_end;

   modport source (output valid, output in_byte, output stream_end, input ready);
   modport sink (input valid, input in_byte, input stream_end, output ready);
endinterface

`default_nettype wire

@@ rtl/crp_rsp_if.sv @@
`default_nettype none

interface crp_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [2:0]                event_res;
   logic [7:0]                hdr_version;
   logic [7:0]                entry_count;
   logic [7:0]                entry_index;
   logic [7:0]                item_type;
   logic [crp_pkg::SIZE_W-1:0] item_size;
   logic [7:0]                data_byte;
   logic                      payload_last;
   logic                      all_done;
   logic [1:0]                error_code;

   modport source (output valid, output event_res, output hdr_version,
                   output entry_count, output entry_index, output item_type,
                   output item_size, output data_byte, output payload_last,
                   output all_done, output error_code, input ready);
   modport sink (input valid, input event_res, input hdr_version,
                 input entry_count, input entry_index, input item_type,
                 input item_size, input data_byte, input payload_last,
                 input all_done, input error_code, output ready);
endinterface

`default_nettype wire

@@ rtl/crp_csr_if.sv @@
`default_nettype none

interface crp_csr_if;
   logic       valid;
   logic       ready;
   logic [0:0] addr;
   logic [7:0] wdata;

   modport source (output valid, output addr, output wdata, input ready);
   modport sink (input valid, input addr, input wdata, output ready);
endinterface

`default_nettype wire

@@ rtl/crp_front.sv @@
`default_nettype none

module crp_front #(
   parameter int SIZE_FIELD_BYTES = crp_pkg::SIZE_FIELD_BYTES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   crp_req_if.sink            req_bus,
   crp_csr_if.sink            csr_bus,
   input  logic               q_ready,
   output crp_pkg::push_type  push
);

   localparam int SCW = (SIZE_FIELD_BYTES > 1) ? $clog2(SIZE_FIELD_BYTES) : 1;
   localparam logic [SCW-1:0] SIZE_LAST = SCW'(SIZE_FIELD_BYTES - 1);
   localparam int SW = crp_pkg::SIZE_W;

   localparam logic [2:0] PH_VERSION = 3'd0;
   localparam logic [2:0] PH_COUNT   = 3'd1;
   localparam logic [2:0] PH_MARKER  = 3'd2;
   localparam logic [2:0] PH_TYPE    = 3'd3;
   localparam logic [2:0] PH_SIZE    = 3'd4;
   localparam logic [2:0] PH_PAYLOAD = 3'd5;
   localparam logic [2:0] PH_IDLE    = 3'd6;

   logic [7:0]     exp_version_ff;
   logic [7:0]     entry_limit_ff;

   logic [2:0]     phase_ff, phase_in;
   logic [SCW-1:0] size_cnt_ff, size_cnt_in;
   logic [7:0]     index_ff, index_in;
   logic [7:0]     count_ff, count_in;
   logic           raw_ff, raw_in;
   logic [7:0]     type_ff, type_in;
   logic [SW-1:0]  size_ff, size_in;
   logic [SW-1:0]  left_ff, left_in;
   logic [7:0]     version_ff, version_in;

   logic           fire;
   logic [7:0]     b;
   logic [SW-1:0]  size_new;
   logic [7:0]     index_nx;
   logic           fin;
   logic           vld_c;
   logic [2:0]     ev_c;
   logic [7:0]     data_c;
   logic           last_c;
   logic           done_c;
   logic [1:0]     err_c;

   assign req_bus.ready = q_ready;
   assign csr_bus.ready = 1'b1;
   assign fire = req_bus.valid & req_bus.ready;
   assign b = req_bus.in_byte;
   assign size_new = {size_ff[SW-9:0], b};
   assign index_nx = index_ff + 8'd1;
   assign fin = (({1'b0, index_ff} + 9'd1) == {1'b0, count_ff});

   always_comb begin
      phase_in    = phase_ff;
      size_cnt_in = size_cnt_ff;
      index_in    = index_ff;
      count_in    = count_ff;
      raw_in      = raw_ff;
      type_in     = type_ff;
      size_in     = size_ff;
      left_in     = left_ff;
      version_in  = version_ff;
      vld_c       = 1'b0;
      ev_c        = crp_pkg::EV_ERROR;
      data_c      = 8'd0;
      last_c      = 1'b0;
      done_c      = 1'b0;
      err_c       = crp_pkg::ERR_BAD_VERSION;

      unique case (phase_ff)
         PH_VERSION: begin
            version_in = b;
            if (b != exp_version_ff) begin
               vld_c    = 1'b1;
               ev_c     = crp_pkg::EV_ERROR;
               err_c    = crp_pkg::ERR_BAD_VERSION;
               phase_in = PH_IDLE;
            end else begin
               phase_in = PH_COUNT;
            end
         end
         PH_COUNT: begin
            count_in = b;
            vld_c    = 1'b1;
            if (b >= entry_limit_ff) begin
               ev_c     = crp_pkg::EV_ERROR;
               err_c    = crp_pkg::ERR_TOO_MANY;
               phase_in = PH_IDLE;
            end else begin
               ev_c     = crp_pkg::EV_HEADER;
               done_c   = (b == 8'd0);
               phase_in = (b == 8'd0) ? PH_IDLE : PH_MARKER;
            end
         end
         PH_MARKER: begin
            if (b[7:1] != 7'd0) begin
               vld_c    = 1'b1;
               ev_c     = crp_pkg::EV_ERROR;
               err_c    = crp_pkg::ERR_UNKNOWN_MARK;
               phase_in = PH_IDLE;
            end else begin
               raw_in   = b[0];
               phase_in = PH_TYPE;
            end
         end
         PH_TYPE: begin
            type_in     = b;
            size_in     = '0;
            size_cnt_in = '0;
            phase_in    = PH_SIZE;
         end
         PH_SIZE: begin
            size_in     = size_new;
            size_cnt_in = size_cnt_ff + SCW'(1);
            if (size_cnt_ff == SIZE_LAST) begin
               vld_c       = 1'b1;
               size_cnt_in = '0;
               if (raw_ff) begin
                  ev_c     = crp_pkg::EV_RAW;
                  done_c   = fin;
                  index_in = index_nx;
                  phase_in = (index_nx == count_ff) ? PH_IDLE : PH_MARKER;
               end else if (size_new == '0) begin
                  ev_c     = crp_pkg::EV_START;
                  last_c   = 1'b1;
                  done_c   = fin;
                  index_in = index_nx;
                  phase_in = (index_nx == count_ff) ? PH_IDLE : PH_MARKER;
               end else begin
                  ev_c     = crp_pkg::EV_START;
                  left_in  = size_new;
                  phase_in = PH_PAYLOAD;
               end
            end
         end
         PH_PAYLOAD: begin
            vld_c  = 1'b1;
            ev_c   = crp_pkg::EV_PAYLOAD;
            data_c = b;
            if (left_ff == SW'(1)) begin
               last_c   = 1'b1;
               done_c   = fin;
               left_in  = '0;
               index_in = index_nx;
               phase_in = (index_nx == count_ff) ? PH_IDLE : PH_MARKER;
            end else begin
               left_in = left_ff - SW'(1);
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase

      push.vld                = fire & vld_c;
      push.res.event_res      = ev_c;
      push.res.hdr_version    = version_in;
      push.res.entry_count    = count_in;
      push.res.entry_index    = index_ff;
      push.res.item_type      = type_in;
      push.res.item_size      = size_in;
      push.res.data_byte      = data_c;
      push.res.payload_last   = last_c;
      push.res.all_done       = done_c;
      push.res.error_code     = err_c;

      if (req_bus.stream_end) begin
         if ((phase_ff != PH_IDLE) && (phase_in != PH_IDLE)) begin
            push.vld                = fire;
            push.res.event_res      = crp_pkg::EV_ERROR;
            push.res.entry_index    = index_in;
            push.res.data_byte      = 8'd0;
            push.res.payload_last   = 1'b0;
            push.res.all_done       = 1'b0;
            push.res.error_code     = crp_pkg::ERR_TRUNCATED;
         end
         phase_in    = PH_VERSION;
         size_cnt_in = '0;
         index_in    = 8'd0;
         count_in    = 8'd0;
         raw_in      = 1'b0;
         type_in     = 8'd0;
         size_in     = '0;
         left_in     = '0;
         version_in  = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_VERSION;
         size_cnt_ff <= '0;
         index_ff    <= 8'd0;
         count_ff    <= 8'd0;
         raw_ff      <= 1'b0;
         type_ff     <= 8'd0;
         size_ff     <= '0;
         left_ff     <= '0;
         version_ff  <= 8'd0;
      end else if (fire) begin
         phase_ff    <= phase_in;
         size_cnt_ff <= size_cnt_in;
         index_ff    <= index_in;
         count_ff    <= count_in;
         raw_ff      <= raw_in;
         type_ff     <= type_in;
         size_ff     <= size_in;
         left_ff     <= left_in;
         version_ff  <= version_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_version_ff <= crp_pkg::VERSION_RST;
         entry_limit_ff <= crp_pkg::LIMIT_RST;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.addr)
            crp_pkg::CSR_EXPECTED_VERSION: exp_version_ff <= csr_bus.wdata;
            crp_pkg::CSR_ENTRY_LIMIT:      entry_limit_ff <= csr_bus.wdata;
            default: begin
            end
         endcase
      end
   end

endmodule

`default_nettype wire

@@ rtl/crp_queue.sv @@
`default_nettype none

`include "result_container_parser_defines.svh"

module crp_queue #(
   parameter int QUEUE_DEPTH = crp_pkg::QUEUE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  crp_pkg::push_type push,
   output logic              in_rdy,
   output logic              out_vld,
   input  logic              out_rdy,
   output crp_pkg::res_type  out_data
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
   localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);

   crp_pkg::res_type mem_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          wr_en;
   logic          rd_en;

   assign in_rdy   = (cnt_ff != CNT_FULL);
   assign out_vld  = (cnt_ff != '0);
   assign out_data = mem_ff[rd_ptr_ff];
   assign wr_en    = push.vld & in_rdy;
   assign rd_en    = out_vld & out_rdy;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PW'(1);
      end
      priority if (wr_en && !rd_en) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (rd_en && !wr_en) begin
         cnt_in = cnt_ff - CW'(1);
      end else begin
         cnt_in = cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= push.res;
      end
   end

   `CRP_ASSERT_IMPL(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= CNT_FULL)
   `CRP_ASSERT_NEXT(a_cnt_up, clock, reset, wr_en && !rd_en, cnt_ff == $past(cnt_ff) + CW'(1))
   `CRP_ASSERT_NEXT(a_cnt_down, clock, reset, rd_en && !wr_en, cnt_ff == $past(cnt_ff) - CW'(1))
   `CRP_ASSERT_NEXT(a_head_hold, clock, reset, out_vld && !rd_en, $stable(out_data))

endmodule

`default_nettype wire

@@ rtl/result_container_parser.sv @@
// container stream parser
// req_bus: one stream byte per beat (in_byte, stream_end marks the final byte)
// csr_bus: register writes, addr 0 expected version, addr 1 entry limit;
//   always ready, write only while no beat is in flight
// rsp_bus: at most one result beat per request beat (header, entry start,
//   payload byte, raw entry or error) with the current header and entry fields
// a result beat is written into the queue when its request beat is taken
// throughput: one request beat per cycle while the queue is not full; each byte
//   is a single state update, plus a 64-bit decrement of the payload counter for a payload byte
// a QUEUE_DEPTH entry queue sits between the parser and rsp_bus; when the
//   receiver stalls, the queue fills and req_bus.ready drops while it is full,
//   with no beat lost or repeated
// reset: parse state returns to expecting a version byte, registers return to
//   version 0 and entry limit 10, the queue is emptied
// after an error or completion, bytes give no result until stream_end, and
//   every stream_end beat returns the parser to the start of a new stream
`default_nettype none

module result_container_parser #(
   parameter int SIZE_FIELD_BYTES = crp_pkg::SIZE_FIELD_BYTES_DEF,
   parameter int QUEUE_DEPTH      = crp_pkg::QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   crp_req_if.sink     req_bus,
   crp_rsp_if.source   rsp_bus,
   crp_csr_if.sink     csr_bus
);

   crp_pkg::push_type push;
   crp_pkg::res_type  head;
   logic              q_ready;

   crp_front #(
      .SIZE_FIELD_BYTES (SIZE_FIELD_BYTES)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .csr_bus (csr_bus),
      .q_ready (q_ready),
      .push    (push)
   );

   crp_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .in_rdy   (q_ready),
      .out_vld  (rsp_bus.valid),
      .out_rdy  (rsp_bus.ready),
      .out_data (head)
   );

   assign rsp_bus.event_res      = head.event_res;
   assign rsp_bus.hdr_version    = head.hdr_version;
   assign rsp_bus.entry_count    = head.entry_count;
   assign rsp_bus.entry_index    = head.entry_index;
   assign rsp_bus.item_type      = head.item_type;
   assign rsp_bus.item_size      = head.item_size;
   assign rsp_bus.data_byte      = head.data_byte;
   assign rsp_bus.payload_last   = head.payload_last;
   assign rsp_bus.all_done       = head.all_done;
   assign rsp_bus.error_code     = head.error_code;

endmodule

`default_nettype wire

@@ tb/sv/crp_parse_monitor.sv @@
module crp_parse_monitor (
   input  logic clock,
   input  logic reset,
   crp_req_if   req_bus,
   crp_rsp_if   rsp_bus,
   crp_csr_if   csr_bus,
   output int   fail_count,
   output int   results_pending
);
   import crp_pkg::*;

   typedef enum logic [2:0] {
      PARSE_VERSION,
      PARSE_COUNT,
      PARSE_MARKER,
      PARSE_TYPE,
      PARSE_SIZE,
      PARSE_PAYLOAD,
      PARSE_IDLE
   } parse_phase_e;

   localparam int         SIZE_BYTES  = SIZE_FIELD_BYTES_DEF;
   localparam int         PRINT_LIMIT = 100;
   localparam logic [1:0] NO_ERROR    = 2'd0;
   localparam logic [7:0] MARK_RAW    = 8'd1;

   logic [7:0]   expected_version;
   logic [7:0]   entry_limit;
   parse_phase_e phase;
   int           size_bytes_seen;
   logic [7:0]   version_seen;
   logic [7:0]   entry_total;
   logic [7:0]   entry_idx;
   logic [7:0]   entry_type;
   logic         raw_entry;
   logic [63:0]  size_value;
   logic [63:0]  payload_left;
   res_type      expected_events[$];

   initial begin
      fail_count = 0;
      results_pending = 0;
   end

   task automatic report_mismatch(input string msg);
      if (fail_count < PRINT_LIMIT) begin
         $display("crp mismatch: %s", msg);
      end
      fail_count++;
   endtask

   task automatic check_field(input string name, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got %0h, wanted %0h", name, got, want));
      end
   endtask

   function automatic void restart_stream();
      phase = PARSE_VERSION;
      size_bytes_seen = 0;
      entry_idx = '0;
      entry_total = '0;
      raw_entry = 1'b0;
      entry_type = '0;
      size_value = '0;
      payload_left = '0;
      version_seen = '0;
   endfunction

   function automatic res_type make_result(input logic [2:0] ev, input logic [7:0] data,
                                           input logic last, input logic done,
                                           input logic [1:0] err);
      res_type r;
      r.event_res = ev;
      r.hdr_version = version_seen;
      r.entry_count = entry_total;
      r.entry_index = entry_idx;
      r.item_type = entry_type;
      r.item_size = size_value;
      r.data_byte = data;
      r.payload_last = last;
      r.all_done = done;
      r.error_code = err;
      return r;
   endfunction

   function automatic logic is_last_entry();
      return ({1'b0, entry_idx} + 9'd1) == {1'b0, entry_total};
   endfunction

   function automatic void close_entry();
      entry_idx = entry_idx + 8'd1;
      phase = (entry_idx == entry_total) ? PARSE_IDLE : PARSE_MARKER;
   endfunction

   function automatic bit parse_stream_byte(input logic [7:0] b, input logic end_byte,
                                            output res_type r);
      bit   has_res;
      bit   was_idle;
      logic done;
      has_res = 1'b0;
      was_idle = (phase == PARSE_IDLE);
      r = '0;
      case (phase)
         PARSE_VERSION: begin
            version_seen = b;
            if (b != expected_version) begin
               r = make_result(EV_ERROR, 8'd0, 1'b0, 1'b0, ERR_BAD_VERSION);
               has_res = 1'b1;
               phase = PARSE_IDLE;
            end else begin
               phase = PARSE_COUNT;
            end
         end
         PARSE_COUNT: begin
            entry_total = b;
            has_res = 1'b1;
            if (b >= entry_limit) begin
               r = make_result(EV_ERROR, 8'd0, 1'b0, 1'b0, ERR_TOO_MANY);
               phase = PARSE_IDLE;
            end else begin
               done = (b == 8'd0);
               r = make_result(EV_HEADER, 8'd0, 1'b0, done, NO_ERROR);
               phase = done ? PARSE_IDLE : PARSE_MARKER;
            end
         end
         PARSE_MARKER: begin
            if (b > MARK_RAW) begin
               r = make_result(EV_ERROR, 8'd0, 1'b0, 1'b0, ERR_UNKNOWN_MARK);
               has_res = 1'b1;
               phase = PARSE_IDLE;
            end else begin
               raw_entry = (b == MARK_RAW);
               phase = PARSE_TYPE;
            end
         end
         PARSE_TYPE: begin
            entry_type = b;
            size_value = '0;
            size_bytes_seen = 0;
            phase = PARSE_SIZE;
         end
         PARSE_SIZE: begin
            size_value = {size_value[55:0], b};
            size_bytes_seen++;
            if (size_bytes_seen == SIZE_BYTES) begin
               done = is_last_entry();
               if (raw_entry) begin
                  r = make_result(EV_RAW, 8'd0, 1'b0, done, NO_ERROR);
                  close_entry();
               end else if (size_value == '0) begin
                  r = make_result(EV_START, 8'd0, 1'b1, done, NO_ERROR);
                  close_entry();
               end else begin
                  r = make_result(EV_START, 8'd0, 1'b0, 1'b0, NO_ERROR);
                  payload_left = size_value;
                  phase = PARSE_PAYLOAD;
               end
               size_bytes_seen = 0;
               has_res = 1'b1;
            end
         end
         PARSE_PAYLOAD: begin
            has_res = 1'b1;
            if (payload_left == 64'd1) begin
               done = is_last_entry();
               r = make_result(EV_PAYLOAD, b, 1'b1, done, NO_ERROR);
               payload_left = '0;
               close_entry();
            end else begin
               r = make_result(EV_PAYLOAD, b, 1'b0, 1'b0, NO_ERROR);
               payload_left = payload_left - 64'd1;
            end
         end
         default: phase = PARSE_IDLE;
      endcase
      if (end_byte) begin
         if (!was_idle && phase != PARSE_IDLE) begin
            r = make_result(EV_ERROR, 8'd0, 1'b0, 1'b0, ERR_TRUNCATED);
            has_res = 1'b1;
         end
         restart_stream();
      end
      return has_res;
   endfunction

   always @(posedge clock) begin : watch_beats
      res_type got;
      res_type want;
      res_type predicted;
      if (reset) begin
         expected_version = VERSION_RST;
         entry_limit = LIMIT_RST;
         restart_stream();
         expected_events.delete();
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.event_res = rsp_bus.event_res;
            got.hdr_version = rsp_bus.hdr_version;
            got.entry_count = rsp_bus.entry_count;
            got.entry_index = rsp_bus.entry_index;
            got.item_type = rsp_bus.item_type;
            got.item_size = rsp_bus.item_size;
            got.data_byte = rsp_bus.data_byte;
            got.payload_last = rsp_bus.payload_last;
            got.all_done = rsp_bus.all_done;
            got.error_code = rsp_bus.error_code;
            if (expected_events.size() == 0) begin
               report_mismatch($sformatf("result beat with none pending, event %0d",
                                         got.event_res));
            end else begin
               want = expected_events.pop_front();
               check_field("event_res", got.event_res, want.event_res);
               check_field("hdr_version", got.hdr_version, want.hdr_version);
               check_field("entry_count", got.entry_count, want.entry_count);
               check_field("entry_index", got.entry_index, want.entry_index);
               check_field("item_type", got.item_type, want.item_type);
               check_field("item_size", got.item_size, want.item_size);
               check_field("data_byte", got.data_byte, want.data_byte);
               check_field("payload_last", got.payload_last, want.payload_last);
               check_field("all_done", got.all_done, want.all_done);
               check_field("error_code", got.error_code, want.error_code);
            end
         end
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.addr)
               CSR_EXPECTED_VERSION: expected_version = csr_bus.wdata;
               CSR_ENTRY_LIMIT: entry_limit = csr_bus.wdata;
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready) begin
            if (parse_stream_byte(req_bus.in_byte, req_bus.stream_end, predicted)) begin
               expected_events.insert(expected_events.size(), predicted);
            end
         end
      end
      results_pending <= expected_events.size();
   end

endmodule

@@ tb/sv/tb_result_container_parser.sv @@
module tb_result_container_parser;
   import crp_pkg::*;

   localparam int         CYCLE_LIMIT   = 300000;
   localparam int         DRAIN_CYCLES  = 6;
   localparam int         HOLD_CYCLES   = 60;
   localparam int         PHASE_BEATS   = 55;
   localparam int         PHASE_COUNT   = 7;
   localparam logic [7:0] MARK_EMBEDDED = 8'd0;
   localparam logic [7:0] MARK_RAW      = 8'd1;

   logic       clock;
   logic       reset;
   logic       hold_request;
   int         fail_count;
   int         results_pending;
   int         cycle_count = 0;
   int         burst_left;
   int         items_sent;
   logic [7:0] cur_version;
   logic [7:0] cur_limit;
   logic [7:0] stream_q[$];

   crp_req_if req_bus ();
   crp_rsp_if rsp_bus ();
   crp_csr_if csr_bus ();

   result_container_parser dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   crp_parse_monitor monitor (
      .clock           (clock),
      .reset           (reset),
      .req_bus         (req_bus),
      .rsp_bus         (rsp_bus),
      .csr_bus         (csr_bus),
      .fail_count      (fail_count),
      .results_pending (results_pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // receiver: random stall pattern that changes from mode to mode, long hold on request
   initial begin : result_sink
      int mode_left;
      int stall_pct;
      int hold_left;
      rsp_bus.ready = 1'b0;
      mode_left = 0;
      stall_pct = 0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_bus.ready <= 1'b0;
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
         end else begin
            if (mode_left == 0) begin
               mode_left = $urandom_range(20, 80);
               case ($urandom_range(0, 3))
                  0: stall_pct = 0;
                  1: stall_pct = 25;
                  2: stall_pct = 50;
                  default: stall_pct = 85;
               endcase
            end
            mode_left--;
            rsp_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   task automatic send_beat(input logic [7:0] data, input logic last);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_bus.valid <= 1'b1;
      req_bus.in_byte <= data;
      req_bus.stream_end <= last;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   task automatic send_stream();
      foreach (stream_q[i]) begin
         send_beat(stream_q[i], i == stream_q.size() - 1);
      end
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (results_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_config(input logic [7:0] version, input logic [7:0] limit);
      csr_bus.valid <= 1'b1;
      csr_bus.addr <= CSR_EXPECTED_VERSION;
      csr_bus.wdata <= version;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.addr <= CSR_ENTRY_LIMIT;
      csr_bus.wdata <= limit;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
      cur_version = version;
      cur_limit = limit;
   endtask

   // mostly well-formed streams with random content, some broken or pure noise
   task automatic random_stream();
      int          kind;
      int          entries;
      int          limit_val;
      int          built;
      int          payload_len;
      int          cut;
      logic [63:0] size;
      logic        raw;
      bit          stop;
      stream_q.delete();
      limit_val = cur_limit;
      kind = $urandom_range(0, 99);
      stop = 1'b0;
      if (kind < 70) begin
         stream_q.insert(stream_q.size(), cur_version);
         if (limit_val == 0) begin
            entries = $urandom_range(0, 255);
         end else if ($urandom_range(0, 14) == 0) begin
            entries = limit_val - 1;
         end else begin
            entries = $urandom_range(0, (limit_val > 5) ? 4 : limit_val - 1);
         end
         stream_q.insert(stream_q.size(), 8'(entries));
         if (limit_val == 0) entries = 0;
         for (built = 0; built < entries && built < 4 && !stop; built++) begin
            if ($urandom_range(0, 19) == 0) begin
               stream_q.insert(stream_q.size(), 8'($urandom_range(2, 255)));
               stop = 1'b1;
            end else begin
               raw = $urandom_range(0, 1);
               stream_q.insert(stream_q.size(), raw ? MARK_RAW : MARK_EMBEDDED);
               stream_q.insert(stream_q.size(), 8'($urandom));
               if (raw) begin
                  size = ($urandom_range(0, 7) == 0) ? '1 : {$urandom, $urandom};
               end else if ($urandom_range(0, 9) == 0) begin
                  size = {$urandom, $urandom};
                  stop = 1'b1;
               end else begin
                  size = 64'($urandom_range(0, 6));
               end
               for (int k = 7; k >= 0; k--) stream_q.insert(stream_q.size(), size[k*8 +: 8]);
               if (!raw) begin
                  payload_len = stop ? $urandom_range(0, 5) : int'(size);
                  repeat (payload_len) stream_q.insert(stream_q.size(), 8'($urandom));
               end
            end
         end
         if ($urandom_range(0, 6) == 0 && stream_q.size() > 1) begin
            cut = $urandom_range(1, stream_q.size() - 1);
            repeat (cut) stream_q.delete(stream_q.size() - 1);
         end
      end else if (kind < 80) begin
         stream_q.insert(stream_q.size(), cur_version ^ 8'($urandom_range(1, 255)));
      end else if (kind < 90) begin
         stream_q.insert(stream_q.size(), cur_version);
         stream_q.insert(stream_q.size(), 8'($urandom_range(limit_val, 255)));
      end else begin
         repeat ($urandom_range(1, 12)) stream_q.insert(stream_q.size(), 8'($urandom));
      end
      items_sent += stream_q.size();
      if ($urandom_range(0, 2) == 0) begin
         repeat ($urandom_range(1, 3)) stream_q.insert(stream_q.size(), 8'($urandom));
      end
      send_stream();
   endtask

   initial begin : stimulus
      int phase_idx;
      int phase_target;
      reset = 1'b1;
      hold_request = 1'b0;
      req_bus.valid = 1'b0;
      req_bus.in_byte = '0;
      req_bus.stream_end = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.addr = CSR_EXPECTED_VERSION;
      csr_bus.wdata = '0;
      burst_left = 0;
      items_sent = 0;
      cur_version = VERSION_RST;
      cur_limit = LIMIT_RST;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // zero entries, bad version, too many entries, unknown marker,
      // truncated after the type byte, embedded entry with empty payload
      stream_q = '{8'h00, 8'h00};
      send_stream();
      stream_q = '{8'hFF, 8'h00};
      send_stream();
      stream_q = '{8'h00, 8'h0A};
      send_stream();
      stream_q = '{8'h00, 8'h01, 8'h02};
      send_stream();
      stream_q = '{8'h00, 8'h01, MARK_EMBEDDED, 8'h7F};
      send_stream();
      stream_q = '{8'h00, 8'h01, MARK_EMBEDDED, 8'h80,
                   8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
      send_stream();
      items_sent = 25;
      drain();

      for (phase_idx = 0; phase_idx < PHASE_COUNT; phase_idx++) begin
         case (phase_idx)
            0: set_config(8'hFF, 8'hFF);
            1: set_config(8'h00, 8'h00);
            2: set_config(8'($urandom), 8'd1);
            3: set_config(8'h5A, 8'd3);
            default: set_config(8'($urandom), 8'($urandom_range(2, 255)));
         endcase
         if (phase_idx == 0 || phase_idx == 3) begin
            // one long embedded entry while the receiver holds off
            hold_request = 1'b1;
            stream_q = '{cur_version, 8'd1, MARK_EMBEDDED, 8'($urandom)};
            repeat (7) stream_q.insert(stream_q.size(), 8'h00);
            stream_q.insert(stream_q.size(), 8'd20);
            repeat (20) stream_q.insert(stream_q.size(), 8'($urandom));
            items_sent += stream_q.size();
            send_stream();
         end
         phase_target = items_sent + PHASE_BEATS;
         while (items_sent < phase_target) random_stream();
         drain();
      end

      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
